### rtl/pidm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types and constants of the PID position motor drive core.
// ----------------------------------------------------------------------------
package pidm_pkg;

    localparam int POS_W   = 32;               // target and encoder positions
    localparam int ERR_W   = 32;               // saturated error
    localparam int DIFF_W  = ERR_W + 1;        // exact difference of two errors
    localparam int SUM_W   = 16;               // stored integral
    localparam int GAIN_W  = 16;               // Q8.8 gains
    localparam int LIM_W   = 15;               // integral limit
    localparam int FRAC_W  = 8;                // fractional bits of the gains

    localparam int PP_W    = GAIN_W + ERR_W;   // proportional product
    localparam int PI_W    = GAIN_W + SUM_W;   // integral product
    localparam int PD_W    = GAIN_W + DIFF_W;  // derivative product
    localparam int ACC_W   = PD_W + 2;         // sum of three products
    localparam int Q_W     = ACC_W - FRAC_W;   // integer part of the sum

    localparam int OUT_MAX = 255;
    localparam int CMD_W   = 17;               // holds +/- OUT_MAX
    localparam int LEVEL_W = 8;
    localparam int DIR_W   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT  = 2'd3;

    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = 16'd128;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = 16'd0;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT  = 15'd128;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [LIM_W-1:0]  integral_limit;
    } t_cfg;

    // load: the stage takes a new item; valid: the item offered from upstream
    typedef struct packed {
        logic load;
        logic valid;
    } t_stage_ctrl;

endpackage
`default_nettype wire

### rtl/pidm_error_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidm_error_stage
// Saturated error, clamped integral and derivative; holds the controller state.
// ----------------------------------------------------------------------------
module pidm_error_stage
    import pidm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_stage_ctrl              i_ctrl,
    input  wire t_cfg                     i_cfg,
    input  wire logic signed [POS_W-1:0]  i_target,
    input  wire logic signed [POS_W-1:0]  i_measured,
    output logic signed [ERR_W-1:0]       o_error,
    output logic signed [SUM_W-1:0]       o_integ,
    output logic signed [DIFF_W-1:0]      o_deriv
);

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ERR_W-1:0]  r_error;
    logic signed [SUM_W-1:0]  r_integ;
    logic signed [DIFF_W-1:0] r_deriv;

    logic signed [POS_W:0]    diff;
    logic signed [ERR_W-1:0]  n_error;
    logic signed [DIFF_W-1:0] integ_raw;
    logic signed [DIFF_W-1:0] lim_pos;
    logic signed [DIFF_W-1:0] lim_neg;
    logic signed [DIFF_W-1:0] integ_cl;
    logic signed [SUM_W-1:0]  n_integ;
    logic signed [DIFF_W-1:0] n_deriv;

    always_comb begin
        diff = {i_target[POS_W-1], i_target} - {i_measured[POS_W-1], i_measured};
        // overflow past 32 bits shows as the top two bits differing
        if (diff[POS_W] != diff[POS_W-1]) begin
            n_error = diff[POS_W] ? ERR_MIN : ERR_MAX;
        end else begin
            n_error = diff[ERR_W-1:0];
        end

        integ_raw = {n_error[ERR_W-1], n_error}
                  + {{(DIFF_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
        lim_pos   = {{(DIFF_W-LIM_W){1'b0}}, i_cfg.integral_limit};
        lim_neg   = -lim_pos;
        if (integ_raw > lim_pos) begin
            integ_cl = lim_pos;
        end else if (integ_raw < lim_neg) begin
            integ_cl = lim_neg;
        end else begin
            integ_cl = integ_raw;
        end
        n_integ = integ_cl[SUM_W-1:0];

        n_deriv = {n_error[ERR_W-1], n_error} - {r_last[ERR_W-1], r_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_ctrl.load && i_ctrl.valid) begin
            r_sum  <= n_integ;
            r_last <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_error <= n_error;
            r_integ <= n_integ;
            r_deriv <= n_deriv;
        end
    end

    assign o_error = r_error;
    assign o_integ = r_integ;
    assign o_deriv = r_deriv;

endmodule
`default_nettype wire

### rtl/pidm_product_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidm_product_stage
// The three gain products, each registered.
// ----------------------------------------------------------------------------
module pidm_product_stage
    import pidm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire t_cfg                     i_cfg,
    input  wire logic signed [ERR_W-1:0]  i_error,
    input  wire logic signed [SUM_W-1:0]  i_integ,
    input  wire logic signed [DIFF_W-1:0] i_deriv,
    output logic signed [PP_W-1:0]        o_p_prop,
    output logic signed [PI_W-1:0]        o_p_integ,
    output logic signed [PD_W-1:0]        o_p_deriv
);

    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [PP_W-1:0]   n_p_prop;
    logic signed [PI_W-1:0]   n_p_integ;
    logic signed [PD_W-1:0]   n_p_deriv;
    logic signed [PP_W-1:0]   r_p_prop;
    logic signed [PI_W-1:0]   r_p_integ;
    logic signed [PD_W-1:0]   r_p_deriv;

    always_comb begin
        kp        = i_cfg.gain_prop;
        ki        = i_cfg.gain_integ;
        kd        = i_cfg.gain_deriv;
        n_p_prop  = kp * i_error;
        n_p_integ = ki * i_integ;
        n_p_deriv = kd * i_deriv;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p_prop  <= n_p_prop;
            r_p_integ <= n_p_integ;
            r_p_deriv <= n_p_deriv;
        end
    end

    assign o_p_prop  = r_p_prop;
    assign o_p_integ = r_p_integ;
    assign o_p_deriv = r_p_deriv;

endmodule
`default_nettype wire

### rtl/pidm_output_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidm_output_stage
// Sum of products, truncation toward zero, saturation, direction and level.
// ----------------------------------------------------------------------------
module pidm_output_stage
    import pidm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire logic signed [PP_W-1:0]   i_p_prop,
    input  wire logic signed [PI_W-1:0]   i_p_integ,
    input  wire logic signed [PD_W-1:0]   i_p_deriv,
    output logic [LEVEL_W-1:0]            o_level,
    output logic [DIR_W-1:0]              o_dir
);

    localparam logic signed [Q_W-1:0] CMD_HI = Q_W'(OUT_MAX);
    localparam logic signed [Q_W-1:0] CMD_LO = -CMD_HI;

    logic signed [ACC_W-1:0] acc;
    logic                    round_up;
    logic signed [Q_W-1:0]   quot;
    logic signed [Q_W-1:0]   cmd_sat;
    logic signed [CMD_W-1:0] cmd;
    logic [CMD_W-1:0]        mag;
    logic [LEVEL_W-1:0]      n_level;
    logic [DIR_W-1:0]        n_dir;
    logic [LEVEL_W-1:0]      r_level;
    logic [DIR_W-1:0]        r_dir;

    always_comb begin
        acc = ACC_W'(i_p_prop) + ACC_W'(i_p_integ) + ACC_W'(i_p_deriv);
        // floor shift, then step back toward zero for negative inexact values
        round_up = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
        quot     = acc[ACC_W-1:FRAC_W] + {{(Q_W-1){1'b0}}, round_up};
        if (quot > CMD_HI) begin
            cmd_sat = CMD_HI;
        end else if (quot < CMD_LO) begin
            cmd_sat = CMD_LO;
        end else begin
            cmd_sat = quot;
        end
        cmd = cmd_sat[CMD_W-1:0];
        mag = cmd[CMD_W-1] ? CMD_W'(-cmd) : cmd;
        n_level = mag[LEVEL_W-1:0];
        if (cmd[CMD_W-1]) begin
            n_dir = DIR_REV;
        end else if (cmd != '0) begin
            n_dir = DIR_FWD;
        end else begin
            n_dir = DIR_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_level <= n_level;
            r_dir   <= n_dir;
        end
    end

    assign o_level = r_level;
    assign o_dir   = r_dir;

endmodule
`default_nettype wire

### rtl/pid_position_motor_drive_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_motor_drive_core
// PID position controller with integral clamp, giving direction and PWM level.
// ----------------------------------------------------------------------------
// Use:
//   slave stream  : one control sample per transfer (target, encoder count)
//   master stream : one drive command per sample (PWM level, direction)
//   config port   : gains and integral limit, written while the core is idle
// A sample taken at the accepting edge passes through the input register, the
// error/integral stage, the product stage and the output register, in that
// order, to its command on the master side. While the receiver accepts, a
// sample is taken every cycle; the integral and previous error close their
// loop inside the error stage, which is what allows the rate of one sample
// per clock.
// When the receiver stalls, the output register holds its command and the
// stages behind it keep filling until each holds an item, after which
// o_s_axis_tready falls. Reset clears the stage valid bits, the integral and
// the previous error, and loads the default gains (kp = 0.5, ki = kd = 0)
// and an integral limit of 128.
// ----------------------------------------------------------------------------
module pid_position_motor_drive_core
    import pidm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [63:0]           i_s_axis_tdata,  // target_position, measured_position
    // master stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [15:0]                o_m_axis_tdata,  // drive_level, direction, zero fill
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic r_va, r_vb, r_vc, r_vd;
    logic adv_a, adv_b, adv_c, adv_d;

    logic signed [POS_W-1:0] r_target;
    logic signed [POS_W-1:0] r_measured;

    t_stage_ctrl ctrl_b;

    logic signed [ERR_W-1:0]  error;
    logic signed [SUM_W-1:0]  integ;
    logic signed [DIFF_W-1:0] deriv;
    logic signed [PP_W-1:0]   p_prop;
    logic signed [PI_W-1:0]   p_integ;
    logic signed [PD_W-1:0]   p_deriv;
    logic [LEVEL_W-1:0]       level;
    logic [DIR_W-1:0]         dir;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop      <= RST_GAIN_PROP;
            r_cfg.gain_integ     <= RST_GAIN_INTEG;
            r_cfg.gain_deriv     <= RST_GAIN_DERIV;
            r_cfg.integral_limit <= RST_INT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:  r_cfg.gain_prop      <= i_cfg_data;
                CFG_GAIN_INTEG: r_cfg.gain_integ     <= i_cfg_data;
                CFG_GAIN_DERIV: r_cfg.gain_deriv     <= i_cfg_data;
                CFG_INT_LIMIT:  r_cfg.integral_limit <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage loads when it is empty or its item moves on
    assign adv_d = !r_vd || i_m_axis_tready;
    assign adv_c = !r_vc || adv_d;
    assign adv_b = !r_vb || adv_c;
    assign adv_a = !r_va || adv_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (adv_a) r_va <= i_s_axis_tvalid;
            if (adv_b) r_vb <= r_va;
            if (adv_c) r_vc <= r_vb;
            if (adv_d) r_vd <= r_vc;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_target   <= i_s_axis_tdata[POS_W-1:0];
            r_measured <= i_s_axis_tdata[2*POS_W-1:POS_W];
        end
    end

    assign ctrl_b = '{load: adv_b, valid: r_va};

    pidm_error_stage u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl_b),
        .i_cfg      (r_cfg),
        .i_target   (r_target),
        .i_measured (r_measured),
        .o_error    (error),
        .o_integ    (integ),
        .o_deriv    (deriv)
    );

    pidm_product_stage u_product (
        .i_clk     (i_clk),
        .i_load    (adv_c),
        .i_cfg     (r_cfg),
        .i_error   (error),
        .i_integ   (integ),
        .i_deriv   (deriv),
        .o_p_prop  (p_prop),
        .o_p_integ (p_integ),
        .o_p_deriv (p_deriv)
    );

    pidm_output_stage u_output (
        .i_clk     (i_clk),
        .i_load    (adv_d),
        .i_p_prop  (p_prop),
        .i_p_integ (p_integ),
        .i_p_deriv (p_deriv),
        .o_level   (level),
        .o_dir     (dir)
    );

    assign o_s_axis_tready = adv_a;
    assign o_m_axis_tvalid = r_vd;
    assign o_m_axis_tdata  = {{(16-LEVEL_W-DIR_W){1'b0}}, dir, level};

endmodule
`default_nettype wire
